FILE: hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   // Number of queue slots (cells in the row).
   localparam int DEPTH = 16;
   // Width of the held-entry counter, wide enough to hold DEPTH itself.
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam int DATA_W = 32;
   localparam int PRIO_W = 32;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_PEEK   = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   // Broadcast to every cell for one transaction.
   typedef struct packed {
      logic              insert;      // accepted insert into a non-full queue
      logic              remove;      // accepted remove from a non-empty queue
      logic              head_yield;  // new entry goes in front of the head
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } cell_cmd_type;

   // What a cell shows its neighbours.
   typedef struct packed {
      logic              valid;
      logic              at_or_after; // insert position is at or before this cell
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } cell_link_type;

endpackage

`default_nettype wire

FILE: hdl/sorted_priority_queue_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_type, req_item_data, req_item_priority
// rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_head_data, rsp_head_priority,
//                                           rsp_is_empty, rsp_entry_count
//
// One transaction a cycle while req_stall is low: a request is decided and applied to
// the cell row in its accepting cycle; its response shows in the output register next cycle.
// The cell row compares every slot against the new priority in parallel; each cell
// shifts, loads or holds on its own, so the cost per request does not depend on DEPTH.
// Reset is synchronous and active high; it empties the queue and drops any response.
// req_stall rises only while a response waits in the output register under rsp_stall.

module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [1:0]               req_type,
   input  wire logic signed [DATA_W-1:0] req_item_data,
   input  wire logic signed [PRIO_W-1:0] req_item_priority,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [1:0]               rsp_status,
   output      logic signed [DATA_W-1:0] rsp_head_data,
   output      logic signed [PRIO_W-1:0] rsp_head_priority,
   output      logic                     rsp_is_empty,
   output      logic [4:0]               rsp_entry_count
);

   logic               accept;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic               queue_empty;
   logic               queue_full;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [PRIO_W-1:0]  rsp_prio_ff, rsp_prio_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;

   cell_cmd_type       cmd;
   cell_link_type      links [DEPTH];
   cell_link_type      edge_link;

   // Hold new requests only while an undelivered response blocks the output register.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign queue_empty = (held_count_ff == '0);
   assign queue_full  = (held_count_ff == COUNT_W'(DEPTH));

   // Broadcast the transaction to the row; drop inserts into a full queue and
   // removes from an empty one.
   always_comb begin
      cmd.insert     = accept && (req_code_type'(req_type) == REQ_INSERT) && !queue_full;
      cmd.remove     = accept && (req_code_type'(req_type) == REQ_REMOVE) && !queue_empty;
      cmd.head_yield = !links[0].valid
                       || ($signed(req_item_priority) < $signed(links[0].prio));
      cmd.data       = req_item_data;
      cmd.prio       = req_item_priority;
   end

   // Tie off both ends of the row: nothing enters from the left, an empty slot from the right.
   always_comb begin
      edge_link.valid       = 1'b0;
      edge_link.at_or_after = 1'b0;
      edge_link.data        = '0;
      edge_link.prio        = '0;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .head_cell  (i == 0),
         .cmd        (cmd),
         .left_link  ((i == 0) ? edge_link : links[(i == 0) ? 0 : i - 1]),
         .right_link ((i == DEPTH - 1) ? edge_link : links[(i == DEPTH - 1) ? i : i + 1]),
         .own_link   (links[i])
      );
   end

   // Advance the count with the row.
   always_comb begin
      held_count_in = held_count_ff;
      if (cmd.insert) begin
         held_count_in = held_count_ff + COUNT_W'(1);
      end else if (cmd.remove) begin
         held_count_in = held_count_ff - COUNT_W'(1);
      end
   end

   // Build the response from the head before this transaction, count and empty after it.
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      rsp_prio_in   = '0;
      case (req_code_type'(req_type))
         REQ_INSERT: begin
            if (queue_full) begin
               rsp_status_in = ST_FULL;
            end
         end
         REQ_REMOVE, REQ_PEEK: begin
            if (queue_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_data_in = links[0].data;
               rsp_prio_in = links[0].prio;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
      rsp_empty_in = (held_count_in == '0);
      rsp_count_in = 5'(held_count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_count_ff <= held_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_data     = rsp_data_ff;
   assign rsp_head_priority = rsp_prio_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

`default_nettype wire

FILE: hdl/spq_cell.sv
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_cell,
   input  wire cell_cmd_type  cmd,
   input  wire cell_link_type left_link,
   input  wire cell_link_type right_link,
   output      cell_link_type own_link
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic              ge_self;
   logic              at_or_after;

   // A free slot or one whose priority is not below the new one stops the search.
   assign ge_self     = !valid_ff || ($signed(prio_ff) >= $signed(cmd.prio));
   assign at_or_after = head_cell ? cmd.head_yield : (cmd.head_yield || ge_self);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (cmd.insert) begin
         if (left_link.at_or_after) begin
            // shift right: take the left neighbour's entry
            valid_in = left_link.valid;
            data_in  = left_link.data;
            prio_in  = left_link.prio;
         end else if (at_or_after) begin
            valid_in = 1'b1;
            data_in  = cmd.data;
            prio_in  = cmd.prio;
         end
      end else if (cmd.remove) begin
         // shift left: take the right neighbour's entry
         valid_in = right_link.valid;
         data_in  = right_link.data;
         prio_in  = right_link.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   always_comb begin
      own_link.valid       = valid_ff;
      own_link.at_or_after = at_or_after;
      own_link.data        = data_ff;
      own_link.prio        = prio_ff;
   end

endmodule

`default_nettype wire
